/* src/srs_pkg.sv */
package srs_pkg;

  // Timer width; action and report timers saturate at 2^TIME_BITS - 1
  localparam int TIME_BITS  = 20;
  localparam int CFG_TIME_W = 20;
  localparam int GUARD_BITS = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  // compare width: wide enough for either operand plus the travel + surplus carry
  localparam int CMP_W = ((TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W) + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_TRAVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_TURN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_SURPLUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_GUARD  = 3'd4;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  typedef enum logic [2:0] {
    MODE_OFF,
    MODE_UP,
    MODE_DOWN,
    MODE_HALF_CLOSE,
    MODE_HALF_OPEN,
    MODE_FULL_OPEN,
    MODE_TURN_OPEN,
    MODE_TURN_CLOSE
  } mode_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] full_travel_ms;
    logic [CFG_TIME_W-1:0] tilt_turn_ms;
    logic [CFG_TIME_W-1:0] travel_surplus_ms;
    logic [CFG_TIME_W-1:0] report_period_ms;
    logic [GUARD_BITS-1:0] switch_guard_ms;
  } srs_cfg_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  initializing;
    logic [TIME_BITS-1:0]  action_timer;
    logic                  timing_active;
    logic [TIME_BITS-1:0]  report_timer;
    logic [GUARD_BITS-1:0] guard_timer;
    logic                  pending_up;
    logic                  pending_down;
    logic                  up_engaged;
    logic                  down_engaged;
    dir_t                  move_direction;
  } srs_state_t;

  localparam srs_state_t STATE_RESET = '{
    mode:           MODE_OFF,
    initializing:   1'b1,
    action_timer:   '0,
    timing_active:  1'b0,
    report_timer:   '0,
    guard_timer:    '0,
    pending_up:     1'b0,
    pending_down:   1'b0,
    up_engaged:     1'b0,
    down_engaged:   1'b0,
    move_direction: DIR_NONE
  };

  typedef struct packed {
    logic  report_pulse;
    mode_t mode_now;
    dir_t  direction;
    logic  relay_down_on;
    logic  relay_up_on;
  } srs_result_t;

endpackage

/* src/shutter_relay_sequencer_top.sv */
// Shutter relay sequencer: one result word per accepted input word.
// Latency: the result is valid on the cycle after the input is accepted.
// Throughput: one word per cycle while m_axis_tready keeps up; the output register frees as it is taken.
// Reset (rst, synchronous): default timings, mode off, startup wait armed,
// timers cleared, no output word pending.
module shutter_relay_sequencer_top import srs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [2:0] command, [7:3] zero
  input  logic [0:0]            s_axis_tuser,   // [0] kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata    // [0] relay_up_on, [1] relay_down_on,
                                                // [3:2] direction, [6:4] mode_now,
                                                // [7] report_pulse
);

  srs_cfg_t    cfg;
  srs_result_t result;
  logic        fire;

  srs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srs_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (fire),
    .in_kind    (s_axis_tuser[0]),
    .in_command (s_axis_tdata[2:0]),
    .result     (result)
  );

  srs_out u_out (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .result        (result),
    .fire          (fire),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* src/srs_cfg.sv */
module srs_cfg import srs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output srs_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_travel_ms    <= CFG_TIME_W'(30000);
      cfg.tilt_turn_ms      <= CFG_TIME_W'(1500);
      cfg.travel_surplus_ms <= CFG_TIME_W'(5000);
      cfg.report_period_ms  <= CFG_TIME_W'(30000);
      cfg.switch_guard_ms   <= GUARD_BITS'(300);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FULL_TRAVEL:    cfg.full_travel_ms    <= cfg_data[CFG_TIME_W-1:0];
        CFG_TILT_TURN:      cfg.tilt_turn_ms      <= cfg_data[CFG_TIME_W-1:0];
        CFG_TRAVEL_SURPLUS: cfg.travel_surplus_ms <= cfg_data[CFG_TIME_W-1:0];
        CFG_REPORT_PERIOD:  cfg.report_period_ms  <= cfg_data[CFG_TIME_W-1:0];
        CFG_SWITCH_GUARD:   cfg.switch_guard_ms   <= cfg_data[GUARD_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* src/srs_core.sv */
module srs_core import srs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  srs_cfg_t    cfg,
  input  logic        fire,
  input  logic        in_kind,
  input  logic [2:0]  in_command,
  output srs_result_t result
);

  srs_state_t       st;
  srs_state_t       st_next;
  logic             pulse;
  logic             do_chg;
  logic             chk;
  mode_t            target;
  logic [CMP_W-1:0] limit;

  always_comb begin
    st_next = st;
    pulse   = 1'b0;
    do_chg  = 1'b0;
    chk     = 1'b0;
    target  = MODE_OFF;
    limit   = '0;

    if (in_kind == KIND_CMD) begin
      do_chg = 1'b1;
      target = mode_t'(in_command);
    end else begin
      if (st.action_timer != '1) st_next.action_timer = st.action_timer + 1'b1;
      if (st.report_timer != '1) st_next.report_timer = st.report_timer + 1'b1;

      // guard countdown, engage when it runs out
      if (st.pending_up || st.pending_down) begin
        if (st.guard_timer <= GUARD_BITS'(1)) begin
          st_next.up_engaged    = st.pending_up;
          st_next.down_engaged  = st.pending_down;
          st_next.pending_up    = 1'b0;
          st_next.pending_down  = 1'b0;
          st_next.guard_timer   = '0;
          st_next.action_timer  = '0;
          st_next.timing_active = 1'b1;
        end else begin
          st_next.guard_timer = st.guard_timer - 1'b1;
        end
      end

      if (CMP_W'(st_next.report_timer) > CMP_W'(cfg.report_period_ms)) begin
        pulse                = 1'b1;
        st_next.report_timer = '0;
      end

      if (st.initializing) begin
        if (CMP_W'(st_next.action_timer) > CMP_W'(cfg.full_travel_ms)) begin
          st_next.initializing = 1'b0;
          do_chg               = 1'b1;
          target               = MODE_OFF;
        end
      end else if (st_next.timing_active) begin
        chk = 1'b1;
        case (st.mode) inside
          MODE_UP, MODE_DOWN: begin
            limit = CMP_W'(cfg.full_travel_ms) + CMP_W'(cfg.travel_surplus_ms);
          end
          MODE_HALF_CLOSE: limit = CMP_W'(cfg.full_travel_ms >> 1);
          MODE_HALF_OPEN: begin
            limit  = CMP_W'(cfg.full_travel_ms >> 1);
            target = MODE_TURN_OPEN;
          end
          MODE_FULL_OPEN: begin
            limit  = CMP_W'(cfg.full_travel_ms);
            target = MODE_TURN_OPEN;
          end
          MODE_TURN_OPEN, MODE_TURN_CLOSE: limit = CMP_W'(cfg.tilt_turn_ms);
          default: chk = 1'b0;
        endcase
        if (chk && (CMP_W'(st_next.action_timer) > limit)) do_chg = 1'b1;
      end
    end

    // mode change: release both relays, then, for a mode that moves or turns, pick the relay for it
    if (do_chg && (target != st.mode)) begin
      st_next.mode         = target;
      pulse                = 1'b1;
      st_next.report_timer = '0;
      st_next.up_engaged   = 1'b0;
      st_next.down_engaged = 1'b0;
      st_next.pending_up   = 1'b0;
      st_next.pending_down = 1'b0;
      st_next.guard_timer  = '0;
      case (target) inside
        MODE_UP, MODE_TURN_OPEN, MODE_DOWN, MODE_FULL_OPEN, MODE_TURN_CLOSE: begin
          if ((target == MODE_UP) || (target == MODE_TURN_OPEN)) begin
            st_next.move_direction = DIR_UP;
            st_next.pending_up     = 1'b1;
          end else begin
            st_next.move_direction = DIR_DOWN;
            st_next.pending_down   = 1'b1;
          end
          st_next.timing_active = 1'b0;
          if (cfg.switch_guard_ms == '0) begin
            st_next.up_engaged    = st_next.pending_up;
            st_next.down_engaged  = st_next.pending_down;
            st_next.pending_up    = 1'b0;
            st_next.pending_down  = 1'b0;
            st_next.action_timer  = '0;
            st_next.timing_active = 1'b1;
          end else begin
            st_next.guard_timer = cfg.switch_guard_ms;
          end
        end
        // half modes leave the action timer running
        MODE_HALF_CLOSE, MODE_HALF_OPEN: st_next.move_direction = DIR_NONE;
        default: begin
          st_next.move_direction = DIR_NONE;
          st_next.timing_active  = 1'b0;
          st_next.action_timer   = '0;
        end
      endcase
    end

    result.relay_up_on   = st_next.up_engaged;
    result.relay_down_on = st_next.down_engaged;
    result.direction     = st_next.move_direction;
    result.mode_now      = st_next.mode;
    result.report_pulse  = pulse;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (fire) begin
      st <= st_next;
    end
  end

  a_relays_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(st.up_engaged && st.down_engaged))
    else $error("both relays engaged");

  a_engaged_timed: assert property (@(posedge clk) disable iff (rst)
    (st.up_engaged || st.down_engaged) |-> st.timing_active)
    else $error("relay engaged without action timing");

  a_pending_guard: assert property (@(posedge clk) disable iff (rst)
    (st.pending_up || st.pending_down) |->
      (st.guard_timer != '0 && !st.timing_active && !st.up_engaged && !st.down_engaged))
    else $error("pending engagement with inconsistent guard state");

  a_off_idle: assert property (@(posedge clk) disable iff (rst)
    (st.mode == MODE_OFF) |->
      (!st.timing_active && !st.pending_up && !st.pending_down && st.move_direction == DIR_NONE))
    else $error("off mode with activity");

endmodule

/* src/srs_out.sv */
module srs_out import srs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  srs_result_t result,
  output logic        fire,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata
);

  srs_result_t held;

  // take a new word whenever the held one is empty or leaving this cycle
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) held <= result;
  end

endmodule
